>>> design/rbm_pkg.sv
// ----------------------------------------------------------------------------
// rbm_pkg
// Shared types, constants and the divider step for the RGB555 blend-mode unit.
// ----------------------------------------------------------------------------
package rbm_pkg;

  localparam int unsigned CH_W    = 5;
  localparam int unsigned PIX_W   = 15;
  localparam int unsigned RED_POS = 10;
  localparam int unsigned GRN_POS = 5;

  localparam logic [CH_W-1:0] CH_MAX = 5'd31;
  localparam logic [CH_W:0]   CH_ONE = 6'd32;

  // Blend rule codes; the unused code passes the background through
  typedef enum logic [2:0] {
    BM_DIFF      = 3'd0,
    BM_INVMUL    = 3'd1,
    BM_SOFT      = 3'd2,
    BM_DODGE     = 3'd3,
    BM_SATADD    = 3'd4,
    BM_LIGHTEN   = 3'd5,
    BM_SOFTDODGE = 3'd6
  } blend_mode_t;

  // Load enables of the four pipeline stages
  typedef struct packed {
    logic ld1;
    logic ld2;
    logic ld3;
    logic ld4;
  } stg_en_t;

  // One restoring-division step: remainder below divisor, divisor 1..32
  typedef struct packed {
    logic [CH_W:0] rem;
    logic          qbit;
  } dstep_t;

  function automatic dstep_t div_step(input logic [CH_W:0] rem, input logic [CH_W:0] dvs);
    logic [CH_W+1:0] dbl;
    dstep_t          res;
    dbl = {rem, 1'b0};
    if (dbl >= {1'b0, dvs}) begin
      res.rem  = (CH_W+1)'(dbl - {1'b0, dvs});
      res.qbit = 1'b1;
    end else begin
      res.rem  = (CH_W+1)'(dbl);
      res.qbit = 1'b0;
    end
    return res;
  endfunction

endpackage

>>> design/rbm_chan.sv
// ----------------------------------------------------------------------------
// rbm_chan
// Four-stage datapath that blends one 5-bit color channel.
// ----------------------------------------------------------------------------
module rbm_chan (
  input  logic                      clk,
  input  rbm_pkg::stg_en_t          en,
  input  logic [2:0]                mode,
  input  logic [rbm_pkg::CH_W-1:0]  spr,
  input  logic [rbm_pkg::CH_W-1:0]  bg,
  output logic [rbm_pkg::CH_W-1:0]  res
);

  localparam int unsigned W = rbm_pkg::CH_W;

  // Stage 1: order the channels, form the products and the sum
  logic [W-1:0]  hi_w, lo_w;
  logic [W:0]    inv_w, cmp_w;
  logic [2*W:0]  psoft_w, pinv_w;

  logic [W-1:0]  s1_b_r, s1_hi_r, s1_lo_r;
  logic [W:0]    s1_inv_r, s1_sum_r;
  logic [2*W-1:0] s1_psoft_r, s1_pinv_r;

  always_comb begin
    hi_w    = (spr > bg) ? spr : bg;
    lo_w    = (spr > bg) ? bg : spr;
    inv_w   = rbm_pkg::CH_ONE - {1'b0, spr};
    cmp_w   = rbm_pkg::CH_ONE - {1'b0, hi_w};
    psoft_w = {{W{1'b0}}, cmp_w} * {{(W+1){1'b0}}, lo_w};
    pinv_w  = {{(W+1){1'b0}}, bg} * {{W{1'b0}}, inv_w};
  end

  always_ff @(posedge clk) begin
    if (en.ld1) begin
      s1_b_r     <= bg;
      s1_hi_r    <= hi_w;
      s1_lo_r    <= lo_w;
      s1_inv_r   <= inv_w;
      s1_sum_r   <= {1'b0, spr} + {1'b0, bg};
      s1_psoft_r <= psoft_w[2*W-1:0];
      s1_pinv_r  <= pinv_w[2*W-1:0];
    end
  end

  // Stage 2: soft value, direct results and division setup
  logic [W:0]    tsum_w;
  logic [W-1:0]  t_w, simple_w, x_w;

  logic [W-1:0]  s2_simple_r;
  logic          s2_ovf_r;
  logic [W:0]    s2_rem_r, s2_d_r;

  always_comb begin
    tsum_w = {1'b0, s1_hi_r} + {1'b0, s1_psoft_r[2*W-1:W]};
    t_w    = tsum_w[W] ? rbm_pkg::CH_MAX : tsum_w[W-1:0];
    case (mode)
      rbm_pkg::BM_DIFF:    simple_w = s1_hi_r - s1_lo_r;
      rbm_pkg::BM_INVMUL:  simple_w = s1_pinv_r[2*W-1:W];
      rbm_pkg::BM_SOFT:    simple_w = t_w;
      rbm_pkg::BM_SATADD:  simple_w = s1_sum_r[W] ? rbm_pkg::CH_MAX : s1_sum_r[W-1:0];
      rbm_pkg::BM_LIGHTEN: simple_w = s1_hi_r;
      default:             simple_w = s1_b_r;
    endcase
    x_w = (mode == rbm_pkg::BM_SOFTDODGE) ? t_w : s1_b_r;
  end

  always_ff @(posedge clk) begin
    if (en.ld2) begin
      s2_simple_r <= simple_w;
      s2_ovf_r    <= ({1'b0, x_w} >= s1_inv_r);
      s2_rem_r    <= {1'b0, x_w};
      s2_d_r      <= s1_inv_r;
    end
  end

  // Stage 3: first three quotient bits
  rbm_pkg::dstep_t st3 [3];

  logic [W-1:0]  s3_simple_r;
  logic          s3_ovf_r;
  logic [W:0]    s3_rem_r, s3_d_r;
  logic [2:0]    s3_q_r;

  always_comb begin
    st3[0] = rbm_pkg::div_step(s2_rem_r, s2_d_r);
    st3[1] = rbm_pkg::div_step(st3[0].rem, s2_d_r);
    st3[2] = rbm_pkg::div_step(st3[1].rem, s2_d_r);
  end

  always_ff @(posedge clk) begin
    if (en.ld3) begin
      s3_simple_r <= s2_simple_r;
      s3_ovf_r    <= s2_ovf_r;
      s3_rem_r    <= st3[2].rem;
      s3_d_r      <= s2_d_r;
      s3_q_r      <= {st3[0].qbit, st3[1].qbit, st3[2].qbit};
    end
  end

  // Stage 4: last two quotient bits, saturate and pick the result
  rbm_pkg::dstep_t st4 [2];
  logic [W-1:0]    div_w, out_w;
  logic [W-1:0]    s4_res_r;

  always_comb begin
    st4[0] = rbm_pkg::div_step(s3_rem_r, s3_d_r);
    st4[1] = rbm_pkg::div_step(st4[0].rem, s3_d_r);
    div_w  = s3_ovf_r ? rbm_pkg::CH_MAX : {s3_q_r, st4[0].qbit, st4[1].qbit};
    out_w  = (mode == rbm_pkg::BM_DODGE || mode == rbm_pkg::BM_SOFTDODGE) ? div_w
                                                                           : s3_simple_r;
  end

  always_ff @(posedge clk) begin
    if (en.ld4) begin
      s4_res_r <= out_w;
    end
  end

  assign res = s4_res_r;

endmodule

>>> design/rgb555_blend_mode_unit_core.sv
// ----------------------------------------------------------------------------
// rgb555_blend_mode_unit_core
// Blends a sprite and a background RGB555 pixel per channel under a mode.
// ----------------------------------------------------------------------------
// The unit takes one pixel pair per clock while in_stall is low and returns the
// blended pixel through a four-stage pipeline (order and multiply, soft value
// and divider setup, three quotient bits, two quotient bits and select). Each
// stage holds only while its successor is full and stalled, so bubbles close
// up and a stalled output does not block input until the pipeline is full.
// blend_mode is written over the APB port at byte address 0 and must only be
// changed while no transaction is in flight.
module rgb555_blend_mode_unit_core (
  input  logic                       clk,
  input  logic                       rst_n,
  // input channel
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [rbm_pkg::PIX_W-1:0]  in_sprite_pixel,
  input  logic [rbm_pkg::PIX_W-1:0]  in_background_pixel,
  // result channel
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [rbm_pkg::PIX_W-1:0]  out_blended_pixel,
  // configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  localparam int unsigned W = rbm_pkg::CH_W;

  // Configuration register
  logic [2:0] mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 3'(rbm_pkg::BM_DIFF);
    end else if (psel && penable && pwrite && !paddr[2]) begin
      mode_r <= pwdata[2:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {29'd0, mode_r};

  // Stage valid bits and per-stage ready
  logic v1_r, v2_r, v3_r, v4_r;
  logic rdy1, rdy2, rdy3, rdy4;
  rbm_pkg::stg_en_t en;

  always_comb begin
    rdy4   = !v4_r || !out_stall;
    rdy3   = !v3_r || rdy4;
    rdy2   = !v2_r || rdy3;
    rdy1   = !v1_r || rdy2;
    en.ld1 = rdy1;
    en.ld2 = rdy2;
    en.ld3 = rdy3;
    en.ld4 = rdy4;
  end

  // Advance valid bits with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  assign in_stall  = !rdy1;
  assign out_valid = v4_r;

  // Channel datapaths
  logic [W-1:0] red_res, grn_res, blu_res;

  rbm_chan u_red (
    .clk  (clk),
    .en   (en),
    .mode (mode_r),
    .spr  (in_sprite_pixel[rbm_pkg::RED_POS +: W]),
    .bg   (in_background_pixel[rbm_pkg::RED_POS +: W]),
    .res  (red_res)
  );

  rbm_chan u_grn (
    .clk  (clk),
    .en   (en),
    .mode (mode_r),
    .spr  (in_sprite_pixel[rbm_pkg::GRN_POS +: W]),
    .bg   (in_background_pixel[rbm_pkg::GRN_POS +: W]),
    .res  (grn_res)
  );

  rbm_chan u_blu (
    .clk  (clk),
    .en   (en),
    .mode (mode_r),
    .spr  (in_sprite_pixel[W-1:0]),
    .bg   (in_background_pixel[W-1:0]),
    .res  (blu_res)
  );

  assign out_blended_pixel = {red_res, grn_res, blu_res};

endmodule
